FILE: sv/frq_pkg.sv
// ----------------------------------------------------------------------------
// Ready queue package
// Shared sizes, operation and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package frq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 8;
   localparam int IDX_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Fixed widths of the result fields.
   localparam int OCC_WIDTH   = 5;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_NOP      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   // Controller states: no result held, or a result waiting for transfer.
   typedef enum logic {
      CS_IDLE   = 1'b0,
      CS_RESULT = 1'b1
   } ctl_state_type;

   // Command from controller to datapath.
   typedef struct packed {
      logic exec;       // run the operation on the request and load the result
   } ctl_cmd_type;

endpackage

FILE: sv/frq_intf.sv
// ----------------------------------------------------------------------------
// Ready queue channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface frq_req_if;
   import frq_pkg::*;

   logic                  valid;
   logic                  ready;
   opcode_type            opcode;
   logic [ID_WIDTH-1:0]   thread_id;

   modport source (output valid, output opcode, output thread_id, input ready);
   modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

interface frq_rsp_if;
   import frq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ID_WIDTH-1:0]   dispatched_id;
   status_type            status;
   logic [OCC_WIDTH-1:0]  occupancy;

   modport source (output valid, output dispatched_id, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input dispatched_id, input status, input occupancy,
                   output ready);
endinterface

FILE: sv/frq_ctrl.sv
// ----------------------------------------------------------------------------
// Ready queue controller
// Tracks whether a result is held and issues the execute command.
// ----------------------------------------------------------------------------
module frq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output frq_pkg::ctl_cmd_type cmd
);
   import frq_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          exec;

   // A new request is taken when the result register is free or being drained.
   assign exec = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (exec) state_in = CS_RESULT;
         end
         CS_RESULT: begin
            if (exec)           state_in = CS_RESULT;
            else if (rsp_ready) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
         end
         CS_RESULT: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.exec = exec;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: sv/frq_dpath.sv
// ----------------------------------------------------------------------------
// Ready queue datapath
// Slot chain with parallel compare, gap closing shift, and result register.
// ----------------------------------------------------------------------------
module frq_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  frq_pkg::ctl_cmd_type             cmd,
   input  frq_pkg::opcode_type              opcode,
   input  logic [frq_pkg::ID_WIDTH-1:0]     thread_id,
   output logic [frq_pkg::ID_WIDTH-1:0]     dispatched_id,
   output frq_pkg::status_type              status,
   output logic [frq_pkg::OCC_WIDTH-1:0]    occupancy
);
   import frq_pkg::*;

   logic [ID_WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   logic [ID_WIDTH-1:0]    disp_ff,   disp_in;
   status_type             status_ff, status_in;
   logic [OCC_WIDTH-1:0]   occ_ff;

   logic [QUEUE_DEPTH-1:0] match;      // valid slot equal to the identifier
   logic [QUEUE_DEPTH-1:0] shift_mask; // slots at or behind the removed entry
   logic                   empty, full, found;
   logic                   do_write, do_shift;
   logic [IDX_WIDTH-1:0]   tail_idx;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign tail_idx = count_ff[IDX_WIDTH-1:0];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
      assign match[i] = (COUNT_WIDTH'(i) < count_ff) && (slot_ff[i] == thread_id);
   end

   // The first match opens the shift region; everything behind it moves up.
   always_comb begin
      shift_mask[0] = match[0];
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         shift_mask[i] = shift_mask[i-1] | match[i];
      end
   end
   assign found = shift_mask[QUEUE_DEPTH-1];

   always_comb begin
      do_write  = 1'b0;
      do_shift  = 1'b0;
      count_in  = count_ff;
      disp_in   = '0;
      status_in = STS_OK;
      unique case (opcode)
         OP_ADD: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               do_write = 1'b1;
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         OP_DISPATCH: begin
            if (empty) begin
               status_in = STS_EMPTY;
            end else begin
               disp_in  = slot_ff[0];
               do_shift = 1'b1;
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         OP_REMOVE: begin
            if (empty) begin
               status_in = STS_EMPTY;
            end else if (!found) begin
               status_in = STS_NOT_FOUND;
            end else begin
               do_shift = 1'b1;
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         default: begin
            status_in = STS_OK;
         end
      endcase
   end

   // Slot chain. Dispatch shifts the whole chain; remove only the masked part.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      logic shift_here;
      assign shift_here = do_shift && ((opcode == OP_DISPATCH) || shift_mask[i]);
      always_ff @(posedge clock) begin
         if (cmd.exec) begin
            if (do_write && (tail_idx == IDX_WIDTH'(i))) begin
               slot_ff[i] <= thread_id;
            end else if (shift_here && (i < QUEUE_DEPTH - 1)) begin
               slot_ff[i] <= slot_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         disp_ff   <= disp_in;
         status_ff <= status_in;
         occ_ff    <= OCC_WIDTH'(count_in);
      end
   end

   assign dispatched_id = disp_ff;
   assign status        = status_ff;
   assign occupancy     = occ_ff;

   // The entry count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   // An add into a full queue leaves the count alone and reports full.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (opcode == OP_ADD) && full |=> full && (status_ff == STS_FULL))
      else $error("add to full queue not dropped");

   // A successful dispatch returns the old head and shortens the queue by one.
   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (opcode == OP_DISPATCH) && !empty
      |=> (disp_ff == $past(slot_ff[0])) && (count_ff == $past(count_ff) - COUNT_WIDTH'(1)))
      else $error("dispatch did not pop the head");

   // A remove that reports not found leaves the count unchanged.
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (opcode == OP_REMOVE) && !empty && !found
      |=> (status_ff == STS_NOT_FOUND) && (count_ff == $past(count_ff)))
      else $error("failed remove changed the queue");

endmodule

FILE: sv/fifo_ready_queue_with_removal_core.sv
// A result is presented in the cycle after its request transfer.
// Throughput: one operation per cycle unless stalled; each finishes in a single
// pass through the slot chain, whose parallel compare and shift set the figure.
// The next request transfer is taken in the same cycle the held result leaves.
// Reset (synchronous, active high) empties the queue and drops any held
// result; slot contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
// Ready queue core
// Round-robin scheduler ready queue: add, dispatch head, remove by identifier.
// ----------------------------------------------------------------------------
module fifo_ready_queue_with_removal_core (
   input  logic       clock,
   input  logic       reset,
   frq_req_if.sink    req_ch,
   frq_rsp_if.source  rsp_ch
);
   import frq_pkg::*;

   // Command path from the controller into the datapath. The controller only
   // decides when a request transfer happens and when the result register is
   // occupied; the datapath does all the queue work in the transfer cycle.
   ctl_cmd_type cmd;

   // The controller holds the response valid flag. A new request is accepted
   // whenever the result register is empty or its contents are being taken
   // in the same cycle, so requests can flow back to back.
   frq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // The datapath keeps the slot chain with the head at slot zero. Adds write
   // at the tail, dispatch shifts every slot toward the head, and remove
   // compares all valid slots at once, picks the match nearest the head and
   // shifts only the slots from there back. The result fields are registered.
   frq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .opcode        (req_ch.opcode),
      .thread_id     (req_ch.thread_id),
      .dispatched_id (rsp_ch.dispatched_id),
      .status        (rsp_ch.status),
      .occupancy     (rsp_ch.occupancy)
   );

endmodule
